@@ rtl/cst_pkg.sv @@
// shared types and constants of the cascaded smoothing tracker
// used by cst_muldiv, the top level and the checker; no dependencies
package cst_pkg;

  localparam int HORIZON  = 10;
  localparam int SAMPLE_W = 13;
  localparam int OUT_W    = 16;
  localparam int WT_W     = 16;
  localparam int PER_W    = 10;
  localparam int POS_W    = 32;
  localparam int VEL_W    = 48;
  localparam int FRAC_W   = 16;
  localparam int H_W      = $clog2(HORIZON + 1);
  localparam int TH_W     = PER_W + H_W;
  localparam int TH2_W    = 2 * TH_W;
  localparam int MB_W     = (TH2_W > WT_W) ? TH2_W : WT_W;
  localparam int DIV_W    = VEL_W + 1;
  localparam int VQ_W     = POS_W + 2;
  localparam int MW       = VEL_W + TH2_W + 2;
  localparam int TERM_W   = 62;
  localparam int RES_W    = 64;
  localparam int CNT_MAX  = (DIV_W > MB_W) ? DIV_W : MB_W;
  localparam int CNT_W    = $clog2(CNT_MAX + 1);
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_W      = 16;

  localparam logic [WT_W-1:0]  POS_WEIGHT_RST = 16'd52429;
  localparam logic [WT_W-1:0]  VEL_WEIGHT_RST = 16'd52429;
  localparam logic [WT_W-1:0]  ACC_WEIGHT_RST = 16'd52429;
  localparam logic [PER_W-1:0] PERIOD_RST     = 10'd20;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POS_WEIGHT,
    REG_VEL_WEIGHT,
    REG_ACC_WEIGHT,
    REG_PERIOD,
    REG_PREDICT
  } cfg_reg_t;

  typedef enum logic {
    OP_MUL,
    OP_DIV
  } md_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_POS,
    ST_VEL,
    ST_FV,
    ST_ACC,
    ST_FA,
    ST_VT,
    ST_AT,
    ST_FIN
  } seq_state_t;

  typedef struct packed {
    logic                  start;
    md_op_t                op;
    logic signed [MW-1:0]  a;
    logic [MB_W-1:0]       b;
    logic [CNT_W-1:0]      n;
  } md_cmd_t;

  typedef struct packed {
    logic                  done;
    logic signed [MW-1:0]  res;
  } md_rsp_t;

endpackage

@@ rtl/cst_muldiv.sv @@
// shared bit-serial unit: shift-add multiply and restoring divide
// signed a times unsigned b, or signed a divided by unsigned b truncated toward zero
// depends on cst_pkg
module cst_muldiv (
  input  logic              clk,
  input  logic              rst,
  input  cst_pkg::md_cmd_t  cmd,
  output cst_pkg::md_rsp_t  rsp
);

  logic                              busy;
  cst_pkg::md_op_t                   op;
  logic [cst_pkg::CNT_W-1:0]         cnt;
  logic signed [cst_pkg::MW-1:0]     acc;
  logic signed [cst_pkg::MW-1:0]     mcand;
  logic [cst_pkg::MB_W-1:0]          mplier;
  logic [cst_pkg::DIV_W-1:0]         mag;
  logic [cst_pkg::DIV_W-1:0]         quo;
  logic [cst_pkg::PER_W-1:0]         rem;
  logic [cst_pkg::PER_W-1:0]         dvsr;
  logic                              neg;
  logic                              done;
  logic signed [cst_pkg::MW-1:0]     res;

  logic signed [cst_pkg::MW-1:0]     acc_next;
  logic [cst_pkg::PER_W:0]           rem_sh;
  logic [cst_pkg::PER_W:0]           rem_sub;
  logic                              qbit;
  logic [cst_pkg::PER_W-1:0]         rem_next;
  logic [cst_pkg::DIV_W-1:0]         quo_next;
  logic signed [cst_pkg::MW-1:0]     quo_ext;
  logic signed [cst_pkg::MW-1:0]     quo_signed;
  logic signed [cst_pkg::MW-1:0]     a_abs;

  assign rsp.done = done;
  assign rsp.res  = res;

  always_comb begin
    acc_next   = mplier[0] ? acc + mcand : acc;
    rem_sh     = {rem, mag[cst_pkg::DIV_W-1]};
    rem_sub    = rem_sh - {1'b0, dvsr};
    qbit       = (rem_sh >= {1'b0, dvsr});
    rem_next   = qbit ? rem_sub[cst_pkg::PER_W-1:0] : rem_sh[cst_pkg::PER_W-1:0];
    quo_next   = {quo[cst_pkg::DIV_W-2:0], qbit};
    quo_ext    = signed'({{(cst_pkg::MW-cst_pkg::DIV_W){1'b0}}, quo_next});
    quo_signed = neg ? -quo_ext : quo_ext;
    a_abs      = cmd.a[cst_pkg::MW-1] ? -cmd.a : cmd.a;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (!busy && cmd.start) begin
        busy <= 1'b1;
        cnt  <= (cmd.op == cst_pkg::OP_DIV) ? cst_pkg::CNT_W'(cst_pkg::DIV_W) : cmd.n;
      end else if (busy) begin
        cnt <= cnt - cst_pkg::CNT_W'(1);
        if (cnt == cst_pkg::CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (!busy && cmd.start) begin
      op     <= cmd.op;
      acc    <= '0;
      mcand  <= cmd.a;
      mplier <= cmd.b;
      neg    <= cmd.a[cst_pkg::MW-1];
      mag    <= a_abs[cst_pkg::DIV_W-1:0];
      dvsr   <= cmd.b[cst_pkg::PER_W-1:0];
      rem    <= '0;
      quo    <= '0;
    end else if (busy) begin
      if (op == cst_pkg::OP_MUL) begin
        acc    <= acc_next;
        mcand  <= mcand <<< 1;
        mplier <= mplier >> 1;
      end else begin
        rem <= rem_next;
        quo <= quo_next;
        mag <= mag << 1;
      end
      if (cnt == cst_pkg::CNT_W'(1)) begin
        res <= (op == cst_pkg::OP_MUL) ? acc_next : quo_signed;
      end
    end
  end

endmodule

@@ rtl/cascaded_smoothing_tracker_core.sv @@
// top level of the cascaded smoothing tracker: ports, configuration, sequencer, state
// depends on cst_pkg and cst_muldiv
//
//  channel  | dir | transfer when        | payload
//  ---------+-----+----------------------+----------------------------------------
//  s_*      | in  | s_tvalid & s_tready  | s_tdata: sample_x[12:0], sample_y[25:13]
//  m_*      | out | m_tvalid & m_tready  | m_tdata: out_x[15:0], out_y[31:16]
//  cfg_*    | in  | cfg_we               | cfg_index selects register, cfg_data
//
// per axis, x and then y, a sample runs through the bit-serial multiply/divide unit one
// operation at a time: position weight multiply, velocity divide, velocity weight multiply,
// acceleration divide, acceleration weight multiply and, with prediction on, two look-ahead
// multiplies; each operation is launched and then awaited, and a write state ends each axis
// s_tready is high only while no sample is in work; a result waits in the output
// register while the next sample is taken, and only the final write stalls on it
// rst is synchronous and clears filter state and the configuration registers to their defaults
module cascaded_smoothing_tracker_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [cst_pkg::IN_DATA_W-1:0]      s_tdata,   // sample_x, sample_y
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [cst_pkg::OUT_DATA_W-1:0]     m_tdata,   // out_x, out_y
  input  logic                               cfg_we,
  input  logic [cst_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cst_pkg::CFG_W-1:0]          cfg_data
);

  localparam logic signed [cst_pkg::MW-1:0] P_MAX =
    signed'({{(cst_pkg::MW-cst_pkg::POS_W+1){1'b0}}, {(cst_pkg::POS_W-1){1'b1}}});
  localparam logic signed [cst_pkg::MW-1:0] P_MIN = -P_MAX - 1;
  localparam logic signed [cst_pkg::MW-1:0] V_MAX =
    signed'({{(cst_pkg::MW-cst_pkg::VEL_W+1){1'b0}}, {(cst_pkg::VEL_W-1){1'b1}}});
  localparam logic signed [cst_pkg::MW-1:0] V_MIN = -V_MAX - 1;
  localparam logic signed [cst_pkg::MW-1:0] T_LIM =
    signed'({{(cst_pkg::MW-61){1'b0}}, 1'b1, 60'd0});
  localparam logic signed [cst_pkg::RES_W-1:0] Q_MAX = 64'sd32767;
  localparam logic signed [cst_pkg::RES_W-1:0] Q_MIN = -64'sd32768;
  localparam logic signed [cst_pkg::RES_W-1:0] RND   = 64'sd65535;

  function automatic logic signed [cst_pkg::MW-1:0] sat(
    input logic signed [cst_pkg::MW-1:0] v,
    input logic signed [cst_pkg::MW-1:0] lo,
    input logic signed [cst_pkg::MW-1:0] hi
  );
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // configuration
  logic [cst_pkg::WT_W-1:0]   pw;
  logic [cst_pkg::WT_W-1:0]   vw;
  logic [cst_pkg::WT_W-1:0]   aw;
  logic [cst_pkg::PER_W-1:0]  period;
  logic                       pe;
  logic [cst_pkg::PER_W-1:0]  t_eff;
  logic [cst_pkg::TH_W-1:0]   th;
  logic [cst_pkg::TH2_W-1:0]  thsq;

  // filter state per coordinate
  logic signed [cst_pkg::POS_W-1:0] fp [2];
  logic signed [cst_pkg::VEL_W-1:0] fv [2];
  logic signed [cst_pkg::VEL_W-1:0] fa [2];
  logic signed [cst_pkg::OUT_W-1:0] lo [2];

  // sequencer and working registers
  cst_pkg::seq_state_t st, st_next;
  logic                              c;
  logic                              fresh;
  logic                              launched;
  logic signed [cst_pkg::SAMPLE_W-1:0] sx;
  logic signed [cst_pkg::SAMPLE_W-1:0] sy;
  logic signed [cst_pkg::POS_W-1:0]  pos;
  logic signed [cst_pkg::VQ_W-1:0]   vel;
  logic signed [cst_pkg::VEL_W-1:0]  nv;
  logic signed [cst_pkg::DIV_W-1:0]  acc;
  logic signed [cst_pkg::VEL_W-1:0]  na;
  logic signed [cst_pkg::TERM_W-1:0] vt;
  logic signed [cst_pkg::TERM_W-1:0] at;

  cst_pkg::md_cmd_t cmd;
  cst_pkg::md_rsp_t rsp;

  logic signed [cst_pkg::SAMPLE_W-1:0] s13;
  logic signed [cst_pkg::OUT_W-1:0]    p;
  logic signed [cst_pkg::OUT_W:0]      d_ps;
  logic signed [cst_pkg::MW-1:0]       r;
  logic signed [cst_pkg::MW-1:0]       pos_t;
  logic signed [cst_pkg::MW-1:0]       nv_t;
  logic signed [cst_pkg::MW-1:0]       na_t;
  logic signed [cst_pkg::MW-1:0]       term_t;
  logic signed [cst_pkg::MW-1:0]       half_t;
  logic signed [cst_pkg::RES_W-1:0]    res;
  logic signed [cst_pkg::RES_W-1:0]    res_t;
  logic signed [cst_pkg::RES_W-1:0]    q;
  logic signed [cst_pkg::RES_W-1:0]    q_sat;
  logic signed [cst_pkg::OUT_W-1:0]    q16;
  logic                                out_slot;

  cst_muldiv u_muldiv (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .rsp (rsp)
  );

  assign s_tready = (st == cst_pkg::ST_IDLE);
  assign t_eff    = (period == '0) ? cst_pkg::PER_W'(1) : period;
  assign out_slot = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    th   <= cst_pkg::TH_W'(t_eff * cst_pkg::HORIZON);
    thsq <= cst_pkg::TH2_W'(th) * cst_pkg::TH2_W'(th);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pw     <= cst_pkg::POS_WEIGHT_RST;
      vw     <= cst_pkg::VEL_WEIGHT_RST;
      aw     <= cst_pkg::ACC_WEIGHT_RST;
      period <= cst_pkg::PERIOD_RST;
      pe     <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        cst_pkg::REG_POS_WEIGHT: pw     <= cfg_data;
        cst_pkg::REG_VEL_WEIGHT: vw     <= cfg_data;
        cst_pkg::REG_ACC_WEIGHT: aw     <= cfg_data;
        cst_pkg::REG_PERIOD:     period <= cfg_data[cst_pkg::PER_W-1:0];
        cst_pkg::REG_PREDICT:    pe     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // operands and result shaping
  always_comb begin
    s13    = c ? sy : sx;
    p      = fresh ? cst_pkg::OUT_W'(s13) : lo[c];
    d_ps   = (cst_pkg::OUT_W+1)'(p) - (cst_pkg::OUT_W+1)'(s13);
    r      = rsp.res;
    pos_t  = sat((cst_pkg::MW'(s13) <<< cst_pkg::FRAC_W) + r, P_MIN, P_MAX);
    nv_t   = sat(cst_pkg::MW'(vel) + (r >>> cst_pkg::FRAC_W), V_MIN, V_MAX);
    na_t   = sat(cst_pkg::MW'(acc) + (r >>> cst_pkg::FRAC_W), V_MIN, V_MAX);
    term_t = sat(r, -T_LIM, T_LIM);
    half_t = term_t >>> 1;
    res    = cst_pkg::RES_W'(pos);
    if (pe) begin
      res = res + cst_pkg::RES_W'(vt) + cst_pkg::RES_W'(at);
    end
    // truncate toward zero
    res_t  = (res < 0) ? res + RND : res;
    q      = res_t >>> cst_pkg::FRAC_W;
    q_sat  = (q < Q_MIN) ? Q_MIN : ((q > Q_MAX) ? Q_MAX : q);
    q16    = q_sat[cst_pkg::OUT_W-1:0];

    cmd       = '0;
    cmd.start = !launched && (st != cst_pkg::ST_IDLE) && (st != cst_pkg::ST_FIN);
    cmd.op    = cst_pkg::OP_MUL;
    cmd.n     = cst_pkg::CNT_W'(cst_pkg::WT_W);
    case (st)
      cst_pkg::ST_POS: begin
        cmd.a = cst_pkg::MW'(d_ps);
        cmd.b = cst_pkg::MB_W'(pw);
      end
      cst_pkg::ST_VEL: begin
        cmd.op = cst_pkg::OP_DIV;
        cmd.a  = cst_pkg::MW'(pos) - (cst_pkg::MW'(p) <<< cst_pkg::FRAC_W);
        cmd.b  = cst_pkg::MB_W'(t_eff);
      end
      cst_pkg::ST_FV: begin
        cmd.a = cst_pkg::MW'(fv[c]) - cst_pkg::MW'(vel);
        cmd.b = cst_pkg::MB_W'(vw);
      end
      cst_pkg::ST_ACC: begin
        cmd.op = cst_pkg::OP_DIV;
        cmd.a  = cst_pkg::MW'(nv) - cst_pkg::MW'(fv[c]);
        cmd.b  = cst_pkg::MB_W'(t_eff);
      end
      cst_pkg::ST_FA: begin
        cmd.a = cst_pkg::MW'(fa[c]) - cst_pkg::MW'(acc);
        cmd.b = cst_pkg::MB_W'(aw);
      end
      cst_pkg::ST_VT: begin
        cmd.a = cst_pkg::MW'(nv);
        cmd.b = cst_pkg::MB_W'(th);
        cmd.n = cst_pkg::CNT_W'(cst_pkg::TH_W);
      end
      cst_pkg::ST_AT: begin
        cmd.a = cst_pkg::MW'(na);
        cmd.b = cst_pkg::MB_W'(thsq);
        cmd.n = cst_pkg::CNT_W'(cst_pkg::TH2_W);
      end
      default: ;
    endcase
  end

  always_comb begin
    st_next = st;
    case (st)
      cst_pkg::ST_IDLE: if (s_tvalid) st_next = cst_pkg::ST_POS;
      cst_pkg::ST_POS:  if (rsp.done) st_next = cst_pkg::ST_VEL;
      cst_pkg::ST_VEL:  if (rsp.done) st_next = cst_pkg::ST_FV;
      cst_pkg::ST_FV:   if (rsp.done) st_next = cst_pkg::ST_ACC;
      cst_pkg::ST_ACC:  if (rsp.done) st_next = cst_pkg::ST_FA;
      cst_pkg::ST_FA: begin
        if (rsp.done) st_next = pe ? cst_pkg::ST_VT : cst_pkg::ST_FIN;
      end
      cst_pkg::ST_VT:   if (rsp.done) st_next = cst_pkg::ST_AT;
      cst_pkg::ST_AT:   if (rsp.done) st_next = cst_pkg::ST_FIN;
      cst_pkg::ST_FIN: begin
        if (!c) begin
          st_next = cst_pkg::ST_POS;
        end else if (out_slot) begin
          st_next = cst_pkg::ST_IDLE;
        end
      end
      default: st_next = cst_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= cst_pkg::ST_IDLE;
    end else begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      launched <= 1'b0;
      m_tvalid <= 1'b0;
      c        <= 1'b0;
      for (int i = 0; i < 2; i++) begin
        fp[i] <= '0;
        fv[i] <= '0;
        fa[i] <= '0;
        lo[i] <= '0;
      end
    end else begin
      if (st == cst_pkg::ST_FIN && c && out_slot) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (cmd.start) launched <= 1'b1;
      if (rsp.done)  launched <= 1'b0;
      if (s_tvalid && s_tready) c <= 1'b0;
      if (st == cst_pkg::ST_FA && rsp.done) begin
        fp[c] <= pos;
        fv[c] <= nv;
        fa[c] <= na_t[cst_pkg::VEL_W-1:0];
      end
      if (st == cst_pkg::ST_FIN) begin
        if (!c) begin
          lo[0] <= q16;
          c     <= 1'b1;
        end else if (out_slot) begin
          lo[1] <= q16;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      sx    <= s_tdata[cst_pkg::SAMPLE_W-1:0];
      sy    <= s_tdata[2*cst_pkg::SAMPLE_W-1:cst_pkg::SAMPLE_W];
      // start-up: no filtered position yet, so the sample stands in for the prediction
      fresh <= (fp[0] == '0) && (fp[1] == '0);
    end
    if (rsp.done) begin
      case (st)
        cst_pkg::ST_POS: pos <= pos_t[cst_pkg::POS_W-1:0];
        cst_pkg::ST_VEL: vel <= r[cst_pkg::VQ_W-1:0];
        cst_pkg::ST_FV:  nv  <= nv_t[cst_pkg::VEL_W-1:0];
        cst_pkg::ST_ACC: acc <= r[cst_pkg::DIV_W-1:0];
        cst_pkg::ST_FA:  na  <= na_t[cst_pkg::VEL_W-1:0];
        cst_pkg::ST_VT:  vt  <= term_t[cst_pkg::TERM_W-1:0];
        cst_pkg::ST_AT:  at  <= half_t[cst_pkg::TERM_W-1:0];
        default: ;
      endcase
    end
    if (st == cst_pkg::ST_FIN && c && out_slot) begin
      m_tdata <= {q16, lo[0]};
    end
  end

endmodule

@@ rtl/cst_checker.sv @@
// port-level checks for cascaded_smoothing_tracker_core, bound to the top level
// depends on cst_pkg
module cst_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic [cst_pkg::IN_DATA_W-1:0]  s_tdata,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [cst_pkg::OUT_DATA_W-1:0] m_tdata
);

  // a sample in work blocks the next one
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while a sample is in work");

  // a result never appears the cycle right after a sample is taken
  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !$rose(m_tvalid))
    else $error("result appeared too early");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled output changed");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("reset did not clear the channels");

endmodule

bind cascaded_smoothing_tracker_core cst_checker u_cst_checker (.*);

@@ tb/tb_cascaded_smoothing_tracker_core.sv @@
// self-checking testbench of the cascaded smoothing tracker: directed table, then random phases
// depends on cst_pkg and cascaded_smoothing_tracker_core; carries its own fixed-point predictor
module tb_cascaded_smoothing_tracker_core;
  timeunit 1ns;
  timeprecision 1ps;
  import cst_pkg::*;

  typedef logic signed [127:0] wide_t;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int PHASE_ITEMS = 250;
  localparam int NUM_PHASES  = 7;

  localparam int MODE_FULL    = 0;
  localparam int MODE_SRC_GAP = 1;
  localparam int MODE_SNK_GAP = 2;
  localparam int MODE_BOTH    = 3;

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [IN_DATA_W-1:0] s_tdata;   // sample_x, sample_y
  logic m_tvalid;
  logic m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;  // out_x, out_y
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  cascaded_smoothing_tracker_core u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // shadow of the configuration and the filter state
  logic [WT_W-1:0] pos_wt, vel_wt, acc_wt;
  logic [PER_W-1:0] period;
  logic predict_on;
  longint fpos_x, fpos_y, fvel_x, fvel_y, facc_x, facc_y, prev_x, prev_y;

  logic [OUT_DATA_W-1:0] expected_pos_q[$];
  int fail_count;
  int idle_mode;

  typedef struct {
    logic signed [SAMPLE_W-1:0] x;
    logic signed [SAMPLE_W-1:0] y;
    bit known;
    logic signed [OUT_W-1:0] ex;
    logic signed [OUT_W-1:0] ey;
  } sample_row_t;

  sample_row_t directed_rows[] = '{
    '{13'sd4095, -13'sd4096, 1'b1, 16'sd4095, -16'sd4096},
    '{-13'sd4096, 13'sd4095, 1'b0, 0, 0},
    '{13'sd0, 13'sd0, 1'b0, 0, 0},
    '{13'sd0, 13'sd0, 1'b0, 0, 0},
    '{13'sd4095, 13'sd4095, 1'b0, 0, 0},
    '{13'sd4095, 13'sd4095, 1'b0, 0, 0},
    '{-13'sd4096, -13'sd4096, 1'b0, 0, 0},
    '{-13'sd4096, -13'sd4096, 1'b0, 0, 0},
    '{13'sd1, -13'sd1, 1'b0, 0, 0},
    '{-13'sd1, 13'sd1, 1'b0, 0, 0},
    '{13'sd2730, -13'sd2731, 1'b0, 0, 0},
    '{-13'sd2731, 13'sd2730, 1'b0, 0, 0},
    '{13'sd100, 13'sd200, 1'b0, 0, 0},
    '{13'sd110, 13'sd210, 1'b0, 0, 0},
    '{13'sd120, 13'sd220, 1'b0, 0, 0},
    '{13'sd130, 13'sd230, 1'b0, 0, 0},
    '{13'sd0, 13'sd0, 1'b0, 0, 0}
  };

  function automatic wide_t smooth_q16(input wide_t old, input wide_t fresh,
                                       input logic [WT_W-1:0] wt);
    wide_t w, s, lim;
    w = 0;
    w[WT_W-1:0] = wt;
    lim = wide_t'(1) <<< 47;
    s = (w * old + (wide_t'(65536) - w) * fresh) >>> 16;
    if (s < -lim) s = -lim;
    if (s > lim - 1) s = lim - 1;
    return s;
  endfunction

  function automatic wide_t clamp_term(input wide_t v);
    wide_t lim;
    lim = wide_t'(1) <<< 60;
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic logic [OUT_W-1:0] track_axis(input longint smp, input longint prv,
                                                  inout longint fp, inout longint fv,
                                                  inout longint fa);
    wide_t w, t, s, p, pos, vel, nv, acc, na, res, q, lim32;
    w = 0;
    w[WT_W-1:0] = pos_wt;
    t = 0;
    t[PER_W-1:0] = period;
    if (t == 0) t = 1;
    s = smp;
    p = prv;
    lim32 = wide_t'(1) <<< 31;
    pos = w * p + (wide_t'(65536) - w) * s;
    if (pos < -lim32) pos = -lim32;
    if (pos > lim32 - 1) pos = lim32 - 1;
    vel = (pos - p * 65536) / t;
    nv = smooth_q16(wide_t'(fv), vel, vel_wt);
    acc = (nv - wide_t'(fv)) / t;
    na = smooth_q16(wide_t'(fa), acc, acc_wt);
    fp = longint'(pos);
    fv = longint'(nv);
    fa = longint'(na);
    if (predict_on)
      res = pos + clamp_term(nv * t * HORIZON)
          + (clamp_term(na * t * t * HORIZON * HORIZON) >>> 1);
    else
      res = pos;
    q = res / 65536;
    if (q < -32768) q = -32768;
    if (q > 32767) q = 32767;
    return q[OUT_W-1:0];
  endfunction

  function automatic logic [OUT_DATA_W-1:0] predict_output(input logic signed [SAMPLE_W-1:0] x,
                                                          input logic signed [SAMPLE_W-1:0] y);
    longint px, py;
    logic [OUT_W-1:0] ox, oy;
    px = prev_x;
    py = prev_y;
    if (fpos_x == 0 && fpos_y == 0) begin
      px = x;
      py = y;
    end
    ox = track_axis(longint'(x), px, fpos_x, fvel_x, facc_x);
    oy = track_axis(longint'(y), py, fpos_y, fvel_y, facc_y);
    prev_x = longint'($signed(ox));
    prev_y = longint'($signed(oy));
    return {oy, ox};
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("Mismatches found");
    $finish;
  end

  // receiver side: stalls depend on the current idling phase
  always @(negedge clk) begin
    if (idle_mode == MODE_SNK_GAP)
      m_tready <= ($urandom_range(99) >= 84);
    else if (idle_mode == MODE_BOTH)
      m_tready <= ($urandom_range(99) >= 12);
    else
      m_tready <= 1'b1;
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_pos_q.size() == 0) begin
        $display("%0t: unexpected result transfer, actual %h", $time, m_tdata);
        fail_count++;
      end else begin
        logic [OUT_DATA_W-1:0] want;
        want = expected_pos_q.pop_front();
        if (want[15:0] !== m_tdata[15:0]) begin
          $display("%0t: out_x expected %0d actual %0d", $time,
                   $signed(want[15:0]), $signed(m_tdata[15:0]));
          fail_count++;
        end
        if (want[31:16] !== m_tdata[31:16]) begin
          $display("%0t: out_y expected %0d actual %0d", $time,
                   $signed(want[31:16]), $signed(m_tdata[31:16]));
          fail_count++;
        end
      end
    end
  end

  // starts at a point after a rising edge; returns right after the accepting edge
  task automatic push_sample(input logic signed [SAMPLE_W-1:0] x,
                             input logic signed [SAMPLE_W-1:0] y);
    int gap_pct;
    gap_pct = (idle_mode == MODE_SRC_GAP) ? 84 : (idle_mode == MODE_BOTH) ? 12 : 0;
    @(negedge clk);
    if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      s_tvalid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < gap_pct);
    end
    s_tdata <= {6'd0, y, x};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    expected_pos_q.push_back(predict_output(x, y));
  endtask

  task automatic drain_block();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (expected_pos_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_POS_WEIGHT: pos_wt = val;
      REG_VEL_WEIGHT: vel_wt = val;
      REG_ACC_WEIGHT: acc_wt = val;
      REG_PERIOD:     period = val[PER_W-1:0];
      REG_PREDICT:    predict_on = val[0];
      default: ;
    endcase
  endtask

  task automatic setup_phase(input int ph);
    case (ph)
      0: ;
      1: begin
        write_reg(REG_POS_WEIGHT, 16'd0);
        write_reg(REG_VEL_WEIGHT, 16'hFFFF);
        write_reg(REG_ACC_WEIGHT, 16'd0);
        write_reg(REG_PERIOD, 16'd1);
      end
      2: begin
        write_reg(REG_POS_WEIGHT, 16'hFFFF);
        write_reg(REG_VEL_WEIGHT, 16'd0);
        write_reg(REG_ACC_WEIGHT, 16'hFFFF);
        write_reg(REG_PERIOD, 16'd1000);
        write_reg(REG_PREDICT, 16'd0);
      end
      3: begin
        // zero period acts as one
        write_reg(REG_PERIOD, 16'd0);
        write_reg(REG_PREDICT, 16'hFFFF);
        write_reg(REG_POS_WEIGHT, 16'($urandom));
        write_reg(REG_VEL_WEIGHT, 16'($urandom));
      end
      4: begin
        // out-of-range period with fast weights drives the look-ahead into saturation
        write_reg(REG_PERIOD, 16'hFFFF);
        write_reg(REG_VEL_WEIGHT, 16'd0);
        write_reg(REG_ACC_WEIGHT, 16'd0);
        write_reg(REG_UNUSED, 16'h1234);
        write_reg(REG_PREDICT, 16'd1);
      end
      default: begin
        write_reg(REG_POS_WEIGHT, 16'($urandom));
        write_reg(REG_VEL_WEIGHT, 16'($urandom));
        write_reg(REG_ACC_WEIGHT, 16'($urandom));
        write_reg(REG_PERIOD, 16'($urandom_range(1023)));
        write_reg(REG_PREDICT, 16'($urandom_range(1)));
      end
    endcase
  endtask

  initial begin
    logic signed [SAMPLE_W-1:0] tx, ty;
    int pick;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    m_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_POS_WEIGHT;
    cfg_data = '0;
    idle_mode = MODE_FULL;
    fail_count = 0;
    pos_wt = POS_WEIGHT_RST;
    vel_wt = VEL_WEIGHT_RST;
    acc_wt = ACC_WEIGHT_RST;
    period = PERIOD_RST;
    predict_on = 1'b1;
    {fpos_x, fpos_y, fvel_x, fvel_y, facc_x, facc_y, prev_x, prev_y} = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      push_sample(directed_rows[i].x, directed_rows[i].y);
      if (directed_rows[i].known)
        expected_pos_q[$] = {directed_rows[i].ey, directed_rows[i].ex};
    end
    drain_block();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      setup_phase(ph);
      idle_mode = ph % 4;
      tx = 0;
      ty = 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(99);
        if (pick < 60) begin
          // smooth trajectory with wrap at the field edges
          tx = tx + $signed(13'($urandom_range(64))) - 13'sd32;
          ty = ty + $signed(13'($urandom_range(64))) - 13'sd32;
        end else if (pick < 85) begin
          tx = 13'($urandom);
          ty = 13'($urandom);
        end else if (pick < 92) begin
          tx = 0;
          ty = 0;
        end else begin
          tx = $urandom_range(1) ? 13'sd4095 : -13'sd4096;
          ty = $urandom_range(1) ? 13'sd4095 : -13'sd4096;
        end
        // hold the sender until the block has gone idle
        if (ph == 4 && $urandom_range(49) == 0) drain_block();
        push_sample(tx, ty);
      end
      drain_block();
    end

    idle_mode = MODE_FULL;
    repeat (500) @(posedge clk);
    if (fail_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
